### hdl/pil_pkg.sv
// ----------------------------------------------------------------------------
// pil_pkg: shared definitions for the positional insert list
// Field widths, request and status codes, and the controller command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package pil_pkg;

  // Field widths of one request beat and one result beat.
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 3;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Packed stream widths, rounded up to whole bytes.
  localparam int S_TDATA_W = ((REQ_W + DATA_W + POS_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((DATA_W + STATUS_W + COUNT_W + 7) / 8) * 8;

  // Default list capacity.
  localparam int DEPTH_DEFAULT = 16;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_POS   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REM_BACK  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ      = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request beat
    logic commit;   // apply the request and load the result register
  } pil_cmd_t;

endpackage

`default_nettype wire

### hdl/pil_datapath.sv
// ----------------------------------------------------------------------------
// pil_datapath: list storage and request execution
// Holds the entry chain, the element count, the captured request and the
// result register. A commit shifts the whole chain in one step.
// ----------------------------------------------------------------------------
`default_nettype none

module pil_datapath #(
  parameter int DEPTH = pil_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pil_pkg::pil_cmd_t             cmd,
  input  wire logic [pil_pkg::REQ_W-1:0]     in_req_type,
  input  wire logic [pil_pkg::DATA_W-1:0]    in_value,
  input  wire logic [pil_pkg::POS_W-1:0]     in_position,
  output logic      [pil_pkg::DATA_W-1:0]    out_data,
  output logic      [pil_pkg::STATUS_W-1:0]  out_status,
  output logic      [pil_pkg::COUNT_W-1:0]   out_count
);

  localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > pil_pkg::POS_W) ? CW : pil_pkg::POS_W;

  // Captured request.
  logic [pil_pkg::REQ_W-1:0]  req_type;
  logic [pil_pkg::DATA_W-1:0] value;
  logic [pil_pkg::POS_W-1:0]  position;

  // List state.
  logic [pil_pkg::DATA_W-1:0] entries [DEPTH];
  logic [pil_pkg::DATA_W-1:0] entries_next [DEPTH];
  logic [CW-1:0]              count;

  // Decode results.
  logic [CMPW-1:0]              cnt_w;
  logic [CMPW-1:0]              pos_w;
  logic [CMPW-1:0]              at_w;
  logic [CMPW-1:0]              count_next;
  logic [IDXW-1:0]              at_idx;
  logic [IDXW-1:0]              rd_idx;
  logic                         do_ins;
  logic                         do_rem;
  logic                         do_rd;
  logic [pil_pkg::STATUS_W-1:0] status_next;
  logic [pil_pkg::DATA_W-1:0]   rd_data;

  assign cnt_w   = CMPW'(count);
  assign pos_w   = CMPW'(position);
  assign at_idx  = at_w[IDXW-1:0];
  assign rd_idx  = do_rem ? at_idx : pos_w[IDXW-1:0];
  assign rd_data = entries[rd_idx];

  // Request decode: target slot, status and count after the request.
  always_comb begin
    at_w        = '0;
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    do_rd       = 1'b0;
    status_next = pil_pkg::ST_OK;
    count_next  = cnt_w;
    unique case (req_type) inside
      pil_pkg::REQ_INS_FRONT, pil_pkg::REQ_INS_BACK, pil_pkg::REQ_INS_POS: begin
        if (req_type == pil_pkg::REQ_INS_FRONT) begin
          at_w = '0;
        end else if (req_type == pil_pkg::REQ_INS_BACK) begin
          at_w = cnt_w;
        end else begin
          at_w = pos_w;
        end
        if (at_w > cnt_w) begin
          status_next = pil_pkg::ST_BADPOS;
        end else if (cnt_w >= CMPW'(DEPTH)) begin
          status_next = pil_pkg::ST_FULL;
        end else begin
          do_ins     = 1'b1;
          count_next = cnt_w + CMPW'(1);
        end
      end
      pil_pkg::REQ_REM_FRONT, pil_pkg::REQ_REM_BACK: begin
        at_w = (req_type == pil_pkg::REQ_REM_FRONT) ? '0 : cnt_w - CMPW'(1);
        if (cnt_w == '0) begin
          status_next = pil_pkg::ST_EMPTY;
        end else begin
          do_rem     = 1'b1;
          count_next = cnt_w - CMPW'(1);
        end
      end
      pil_pkg::REQ_READ: begin
        if (cnt_w == '0) begin
          status_next = pil_pkg::ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status_next = pil_pkg::ST_BADPOS;
        end else begin
          do_rd = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Per-entry next value: open a gap at the slot or close the gap there.
  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    logic [pil_pkg::DATA_W-1:0] below;
    logic [pil_pkg::DATA_W-1:0] above;
    // Slot zero never shifts up from below; the captured value stands in.
    if (i == 0) begin : g_first
      assign below = value;
    end else begin : g_mid
      assign below = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign above = entries[i];
    end else begin : g_top
      assign above = entries[i+1];
    end

    always_comb begin
      entries_next[i] = entries[i];
      if (do_ins) begin
        if (IDXW'(i) == at_idx) begin
          entries_next[i] = value;
        end else if (IDXW'(i) > at_idx) begin
          entries_next[i] = below;
        end
      end else if (do_rem) begin
        if (IDXW'(i) >= at_idx) begin
          entries_next[i] = above;
        end
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type <= in_req_type;
      value    <= in_value;
      position <= in_position;
    end
  end

  // Entry chain and result payload.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (do_ins || do_rem) begin
        for (int k = 0; k < DEPTH; k++) begin
          entries[k] <= entries_next[k];
        end
      end
      out_data   <= (do_rem || do_rd) ? rd_data : '0;
      out_status <= status_next;
      out_count  <= count_next[pil_pkg::COUNT_W-1:0];
    end
  end

  // Element count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next[CW-1:0];
    end
  end

endmodule

`default_nettype wire

### hdl/pil_ctrl.sv
// ----------------------------------------------------------------------------
// pil_ctrl: request sequencer
// Accepts one request beat, commits it once the result register is free,
// and tracks the result beat's valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pil_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output pil_pkg::pil_cmd_t      cmd
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready    = (state == IDLE);
  assign out_free    = !m_tvalid || m_tready;
  assign cmd.capture = s_tvalid && s_tready;
  assign cmd.commit  = (state == EXEC) && out_free;

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (m_tvalid && m_tready) begin
            m_tvalid <= 1'b0;
          end
          if (cmd.capture) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/positional_insert_list.sv
// ----------------------------------------------------------------------------
// positional_insert_list: bounded ordered list of signed 32-bit values
// Requests insert, remove or read entries; each returns one result beat.
// ----------------------------------------------------------------------------
// Each request beat produces exactly one result beat carrying the removed or
// read data, a status code and the new element count. A request is first
// captured into the request register and then executed against the
// register chain, which shifts every entry in a single step. The execute
// step waits while the previous result beat is still held on the master
// side, but a new request is accepted while that result waits. There is no
// clearing pass after reset; entries that were never written are never read.
`default_nettype none

module positional_insert_list #(
  parameter int DEPTH = pil_pkg::DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Request beat: req_type [2:0], value [34:3], position [39:35].
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [pil_pkg::S_TDATA_W-1:0]   s_tdata,
  // Result beat: data [31:0], status [33:32], count [38:34], zero [39].
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [pil_pkg::M_TDATA_W-1:0]   m_tdata
);

  localparam int VAL_LO = pil_pkg::REQ_W;
  localparam int POS_LO = pil_pkg::REQ_W + pil_pkg::DATA_W;

  pil_pkg::pil_cmd_t               cmd;
  logic [pil_pkg::DATA_W-1:0]      out_data;
  logic [pil_pkg::STATUS_W-1:0]    out_status;
  logic [pil_pkg::COUNT_W-1:0]     out_count;

  // Sequencer.
  pil_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // Storage and execution.
  pil_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_req_type (s_tdata[pil_pkg::REQ_W-1:0]),
    .in_value    (s_tdata[VAL_LO +: pil_pkg::DATA_W]),
    .in_position (s_tdata[POS_LO +: pil_pkg::POS_W]),
    .out_data    (out_data),
    .out_status  (out_status),
    .out_count   (out_count)
  );

  // Pack the result beat, low field first, padded with zeros.
  assign m_tdata = pil_pkg::M_TDATA_W'({out_count, out_status, out_data});

endmodule

`default_nettype wire
